// ----- src/ilp_pkg.sv -----
// Package for the integer literal parser: payload structs, item classes,
// status codes and character constants.
// Depends on nothing; every other file of the block imports it.
package ilp_pkg;

  // Configuration port widths and register indexes.
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgIdxIsSigned  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxWidthIs64 = 8'd1;

  // Characters with a special role.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7a;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5a;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;

  // Digit value of the first letter.
  localparam logic [5:0] LetterBase = 6'd10;

  // Result status codes.
  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StEmpty    = 3'd1,
    StSign     = 3'd2,
    StNoDigits = 3'd3,
    StPrefix   = 3'd4,
    StBadDigit = 3'd5,
    StOverflow = 3'd6,
    StRange    = 3'd7
  } status_e;

  // Character classes that steer the parser apart from the digit value.
  typedef enum logic [1:0] {
    ClsOther = 2'd0,
    ClsPlus  = 2'd1,
    ClsMinus = 2'd2,
    ClsX     = 2'd3
  } char_cls_e;

  // Input item as it arrives on the port.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       last;
  } in_item_t;

  // Result item as it leaves on the port.
  typedef struct packed {
    logic [63:0] magnitude;
    logic        negative;
    status_e     status;
  } res_item_t;

  // Classified item held in the queue between front and back.
  typedef struct packed {
    logic      has_char;
    logic      last;
    char_cls_e cls;
    logic      digit_ok;
    logic [5:0] digit;
  } cls_item_t;

  // Configuration registers as seen by the back end.
  typedef struct packed {
    logic is_signed;
    logic width_is_64;
  } cfg_t;

endpackage

// ----- src/ilp_front.sv -----
// Front end of the integer literal parser: classifies each character into
// a digit value and a sign/prefix class and hands it to the queue.
// Depends on ilp_pkg.
module ilp_front import ilp_pkg::*; (
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      push_valid_o,
  input  logic      push_ready_i,
  output cls_item_t push_data_o
);

  logic [7:0] c;

  assign c = in_data_i.char_byte;

  // The transfer goes straight on into the queue.
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

  // Digit value in bases up to 36 and character class.
  always_comb begin
    push_data_o.has_char = in_data_i.has_char;
    push_data_o.last     = in_data_i.last;
    push_data_o.digit_ok = 1'b1;
    push_data_o.digit    = '0;
    if (c >= CharZero && c <= CharNine) begin
      push_data_o.digit = 6'(c - CharZero);
    end else if (c >= CharLowA && c <= CharLowZ) begin
      push_data_o.digit = 6'(c - CharLowA) + LetterBase;
    end else if (c >= CharUpA && c <= CharUpZ) begin
      push_data_o.digit = 6'(c - CharUpA) + LetterBase;
    end else begin
      push_data_o.digit_ok = 1'b0;
    end

    if (c == CharPlus) begin
      push_data_o.cls = ClsPlus;
    end else if (c == CharMinus) begin
      push_data_o.cls = ClsMinus;
    end else if (c == CharLowX || c == CharUpX) begin
      push_data_o.cls = ClsX;
    end else begin
      push_data_o.cls = ClsOther;
    end
  end

endmodule

// ----- src/ilp_queue.sv -----
// Short first-in first-out queue between the front and back of the parser.
// Depends on ilp_pkg only by convention; the payload is a plain bit vector.
module ilp_queue import ilp_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/ilp_back.sv -----
// Back end of the integer literal parser: the literal state machine, the
// 64-bit accumulator, the range check and the result register.
// Depends on ilp_pkg.
module ilp_back import ilp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  cls_item_t item_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output res_item_t res_o
);

  typedef enum logic [2:0] {
    PhStart, PhAfterSign, PhZero, PhPrefixX, PhDigits, PhHalted
  } phase_e;

  typedef enum logic [1:0] {
    RadixDec, RadixOct, RadixHex
  } radix_e;

  localparam logic [5:0] Radix10 = 6'd10;
  localparam logic [5:0] Radix8  = 6'd8;
  localparam logic [5:0] Radix16 = 6'd16;

  phase_e      phase_q, phase_d;
  radix_e      radix_q, radix_d, radix_step;
  logic [63:0] acc_q, acc_d;
  logic        minus_q, minus_d;
  status_e     err_q, err_d;
  logic        res_valid_q, res_valid_d;
  res_item_t   res_q, res_d;

  logic        take;
  logic [5:0]  radix_val;
  logic [67:0] prod, sum;
  logic        bad_digit, overflow, is_zero_char;
  logic        out_of_range;

  // A non-final item never waits; a final one waits for room in the result register.
  assign item_ready_o = !item_i.last || !res_valid_q || res_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  assign is_zero_char = item_i.digit_ok && (item_i.digit == '0);

  // Radix a digit in this step would be taken in.
  always_comb begin
    case (phase_q)
      PhStart, PhAfterSign: radix_step = RadixDec;
      PhZero:               radix_step = RadixOct;
      default:              radix_step = radix_q;
    endcase
    case (radix_step)
      RadixHex: radix_val = Radix16;
      RadixOct: radix_val = Radix8;
      default:  radix_val = Radix10;
    endcase
  end

  // Multiply-add by a constant radix as shifts and adds; carry out of bit 63 is overflow.
  always_comb begin
    case (radix_step)
      RadixHex: prod = {acc_q, 4'b0};
      RadixOct: prod = {1'b0, acc_q, 3'b0};
      default:  prod = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0};
    endcase
    sum       = prod + {62'b0, item_i.digit};
    bad_digit = !item_i.digit_ok || (item_i.digit >= radix_val);
    overflow  = (sum[67:64] != '0);
  end

  // Character step, then the end-of-literal check on the updated state.
  always_comb begin
    phase_d      = phase_q;
    radix_d      = radix_q;
    acc_d        = acc_q;
    minus_d      = minus_q;
    err_d        = err_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    res_d        = res_q;
    out_of_range = 1'b0;

    if (take && item_i.has_char) begin
      if (phase_q == PhStart && (item_i.cls == ClsPlus || item_i.cls == ClsMinus)) begin
        if (!cfg_i.is_signed) begin
          err_d   = StSign;
          phase_d = PhHalted;
        end else begin
          minus_d = (item_i.cls == ClsMinus);
          phase_d = PhAfterSign;
        end
      end else if ((phase_q == PhStart || phase_q == PhAfterSign) && is_zero_char) begin
        phase_d = PhZero;
      end else if (phase_q == PhZero && item_i.cls == ClsX) begin
        radix_d = RadixHex;
        phase_d = PhPrefixX;
      end else if (phase_q != PhHalted) begin
        // Ordinary digit in the current radix.
        radix_d = radix_step;
        phase_d = PhDigits;
        if (err_q == StOk) begin
          if (bad_digit) begin
            err_d = StBadDigit;
          end else if (overflow) begin
            err_d = StOverflow;
          end else begin
            acc_d = sum[63:0];
          end
        end
      end
    end

    if (take && item_i.last) begin
      // Range check against the configured width and signedness.
      if (cfg_i.is_signed) begin
        if (cfg_i.width_is_64) begin
          out_of_range = minus_d ? (acc_d[63] && (acc_d[62:0] != '0)) : acc_d[63];
        end else begin
          out_of_range = minus_d ? ((acc_d[63:32] != '0) || (acc_d[31] && (acc_d[30:0] != '0)))
                                 : (acc_d[63:31] != '0);
        end
      end else begin
        out_of_range = !cfg_i.width_is_64 && (acc_d[63:32] != '0);
      end

      case (phase_d)
        PhStart:     res_d.status = StEmpty;
        PhAfterSign: res_d.status = StNoDigits;
        PhPrefixX:   res_d.status = StPrefix;
        PhHalted:    res_d.status = err_d;
        default: begin
          if (err_d != StOk) begin
            res_d.status = err_d;
          end else if (out_of_range) begin
            res_d.status = StRange;
          end else begin
            res_d.status = StOk;
          end
        end
      endcase
      res_d.magnitude = (res_d.status == StOk) ? acc_d : '0;
      res_d.negative  = minus_d;
      res_valid_d     = 1'b1;

      // Back to the start of a new literal.
      phase_d = PhStart;
      radix_d = RadixDec;
      acc_d   = '0;
      minus_d = 1'b0;
      err_d   = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStart;
      radix_q     <= RadixDec;
      acc_q       <= '0;
      minus_q     <= 1'b0;
      err_q       <= StOk;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      radix_q     <= radix_d;
      acc_q       <= acc_d;
      minus_q     <= minus_d;
      err_q       <= err_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ----- src/integer_literal_parser.sv -----
// Channel   | Signals                                | Moves
// ----------+----------------------------------------+----------------------------
// input     | in_valid_i, in_ready_o, in_data_i      | one character per transfer
// output    | out_valid_o, out_ready_i, out_data_o   | one result per literal
// config    | cfg_valid_i, cfg_ready_o, cfg_index_i, | one register write
//           | cfg_data_i                             |
//
// One character is taken every cycle; the 64-bit multiply-add by the radix
// in the back end sets that step. With the back end free, the final character
// is stored in the queue, then its result in the result register. Reset
// returns to the start of a literal with signed 64-bit range. The queue lets
// input keep flowing while a result waits; input stalls only when the queue is full.
//
// Top level of the integer literal parser; depends on ilp_pkg, ilp_front,
// ilp_queue and ilp_back.
module integer_literal_parser import ilp_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output res_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  logic      push_valid, push_ready;
  cls_item_t push_data, pop_data;
  logic      pop_valid, pop_ready;

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxIsSigned:  cfg_d.is_signed   = cfg_data_i[0];
        CfgIdxWidthIs64: cfg_d.width_is_64 = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{is_signed: 1'b1, width_is_64: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Character classification.
  ilp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decoupling queue.
  ilp_queue #(
    .Width ($bits(cls_item_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Parsing state machine and result register.
  ilp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .item_i       (pop_data),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (out_data_o)
  );

`ifndef ASSERT_OFF
  // A failed literal never reports a value.
  a_err_no_magnitude: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StOk) |-> (out_data_o.magnitude == '0))
    else $error("nonzero magnitude on a failed literal");

  // An empty literal cannot have seen a minus sign.
  a_empty_not_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StEmpty) |-> !out_data_o.negative)
    else $error("empty literal flagged negative");

  // A new result comes only from an item taken out of the queue.
  a_result_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop_valid && pop_ready && pop_data.last))
    else $error("result without a final queued item");
`endif

endmodule
